// ===== rtl/core/cobs_crc_frame_deframer_macros.svh =====
// Assertion helpers used by the deframer back end RTL.
`ifndef COBS_CRC_FRAME_DEFRAMER_MACROS_SVH
`define COBS_CRC_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CCFD_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CCFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ccfd_pkg.sv =====
`default_nettype none
package ccfd_pkg;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_DATA,
    KIND_DELIM
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [8:0]  payload_index;
  } item_t;

  typedef struct packed {
    logic [15:0] frame_magic;
    logic [7:0]  protocol_version;
    logic [63:0] known_command_mask;
    logic [8:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  decode_result;
    logic [2:0]  error_code;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [7:0]  frame_flags;
    logic [31:0] sequence_number;
    logic [31:0] byte_offset;
    logic [8:0]  payload_length;
    logic [15:0] frame_status;
    logic [7:0]  payload_byte;
    logic [31:0] dropped_count;
  } result_t;

  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_GOOD = 2'd1;
  localparam logic [1:0] RES_DROP = 2'd2;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_INVALID = 3'd1;
  localparam logic [2:0] ERR_LEN     = 3'd2;
  localparam logic [2:0] ERR_CRC     = 3'd3;
  localparam logic [2:0] ERR_VERSION = 3'd4;
  localparam logic [2:0] ERR_CMD     = 3'd5;

  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_CMDMASK = 2'd2;
  localparam logic [1:0] REG_MAXPAY  = 2'd3;

  localparam int HDR_BYTES = 18;
  localparam int HDR_IW    = $clog2(HDR_BYTES);
  localparam int CRC_BYTES = 4;
  localparam int MIN_FRAME = HDR_BYTES + CRC_BYTES;

  localparam int OFS_VERSION = 2;
  localparam int OFS_CMD     = 3;
  localparam int OFS_FLAGS   = 4;
  localparam int OFS_RSVD    = 5;
  localparam int OFS_SEQ     = 6;
  localparam int OFS_OFFSET  = 10;
  localparam int OFS_PLEN    = 14;
  localparam int OFS_STATUS  = 16;

  localparam logic [7:0]  COBS_LONG_CODE = 8'hFF;
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cobs_crc_frame_deframer.sv =====
`default_nettype none
// COBS deframer with CRC-32 check. Push transactions carry one link byte or a
// payload read; each one accepted yields exactly one result, in order. A zero
// byte ends a frame and the result then reports good or dropped, with the
// header fields of the last good frame and the dropped-frame count. A front
// queue (4 deep) classifies transactions; the back end runs one per cycle
// while the result queue has room, so one transaction per clock is sustained,
// results passing a result stage register and a 4-deep result queue. The rate
// is set by the combinational CRC byte update and the one write port plus one
// read port of the raw buffer RAM, whose read data arrives in the cycle after
// its address; reading a position unwritten since reset gives an undefined byte.
// Registers sit at byte addresses 0, 8, 16, 24 (magic, version, command mask,
// max payload) on a 64-bit APB port and must be written only while idle.
module cobs_crc_frame_deframer #(
  parameter int RAW_DEPTH     = 512,
  parameter int ENCODED_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [8:0]  in_payload_index,
  // result channel
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_decode_result,
  output logic [2:0]       out_error_code,
  output logic [7:0]       out_frame_version,
  output logic [7:0]       out_frame_command,
  output logic [7:0]       out_frame_flags,
  output logic [31:0]      out_sequence_number,
  output logic [31:0]      out_byte_offset,
  output logic [8:0]       out_payload_length,
  output logic [15:0]      out_frame_status,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_dropped_count,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  ccfd_pkg::cfg_t    cfg_r;
  ccfd_pkg::item_t   q_item;
  ccfd_pkg::result_t res;
  logic              q_valid, q_pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register file; index is paddr[4:3]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_magic        <= 16'd0;
      cfg_r.protocol_version   <= 8'd1;
      cfg_r.known_command_mask <= 64'd0;
      cfg_r.max_payload        <= 9'd256;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        ccfd_pkg::REG_MAGIC:   cfg_r.frame_magic        <= pwdata[15:0];
        ccfd_pkg::REG_VERSION: cfg_r.protocol_version   <= pwdata[7:0];
        ccfd_pkg::REG_CMDMASK: cfg_r.known_command_mask <= pwdata;
        ccfd_pkg::REG_MAXPAY:  cfg_r.max_payload        <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      ccfd_pkg::REG_MAGIC:   prdata = {48'd0, cfg_r.frame_magic};
      ccfd_pkg::REG_VERSION: prdata = {56'd0, cfg_r.protocol_version};
      ccfd_pkg::REG_CMDMASK: prdata = cfg_r.known_command_mask;
      ccfd_pkg::REG_MAXPAY:  prdata = {55'd0, cfg_r.max_payload};
      default:               prdata = 64'd0;
    endcase
  end

  ccfd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .in_payload_index (in_payload_index),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  ccfd_back #(
    .RAW_DEPTH     (RAW_DEPTH),
    .ENCODED_DEPTH (ENCODED_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_decode_result   = res.decode_result;
  assign out_error_code      = res.error_code;
  assign out_frame_version   = res.frame_version;
  assign out_frame_command   = res.frame_command;
  assign out_frame_flags     = res.frame_flags;
  assign out_sequence_number = res.sequence_number;
  assign out_byte_offset     = res.byte_offset;
  assign out_payload_length  = res.payload_length;
  assign out_frame_status    = res.frame_status;
  assign out_payload_byte    = res.payload_byte;
  assign out_dropped_count   = res.dropped_count;
endmodule
`default_nettype wire

// ===== rtl/core/ccfd_ram.sv =====
`default_nettype none
module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ccfd_front.sv =====
`default_nettype none
// Input queue: classifies each transaction and holds it for the back end.
module ccfd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_command,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic [8:0]    in_payload_index,
  output logic               q_valid,
  output ccfd_pkg::item_t    q_item,
  input  wire logic          q_pop
);
  ccfd_pkg::item_t                 mem_r [ccfd_pkg::IQ_DEPTH];
  logic [ccfd_pkg::IQ_AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ccfd_pkg::IQ_CW-1:0]      cnt_r, cnt_nxt;
  ccfd_pkg::item_t                 item;
  logic                            push_ok;

  always_comb begin
    item.data_byte     = in_data_byte;
    item.payload_index = in_payload_index;
    if (in_command) begin
      item.kind = ccfd_pkg::KIND_READ;
    end else if (in_data_byte != 8'd0) begin
      item.kind = ccfd_pkg::KIND_DATA;
    end else begin
      item.kind = ccfd_pkg::KIND_DELIM;
    end
  end

  assign in_full = (cnt_r == ccfd_pkg::IQ_CW'(ccfd_pkg::IQ_DEPTH));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + ccfd_pkg::IQ_CW'(push_ok) - ccfd_pkg::IQ_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= item;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ccfd_back.sv =====
`default_nettype none
`include "cobs_crc_frame_deframer_macros.svh"
// Executes one queued transaction per cycle, stalling while the small output
// queue has no room: COBS unstuffing, lagging CRC, frame checks, payload reads.
module ccfd_back #(
  parameter int RAW_DEPTH     = 512,
  parameter int ENCODED_DEPTH = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ccfd_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire ccfd_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output ccfd_pkg::result_t    out_res
);
  localparam int RAW_AW = $clog2(RAW_DEPTH);
  localparam int RCW    = $clog2(RAW_DEPTH + 1);
  localparam int ECW    = $clog2(ENCODED_DEPTH + 1);
  localparam int GW     = (RCW > 8) ? RCW : 8;
  localparam int BW     = (RCW > 17) ? RCW : 17;
  localparam int PW     = (RAW_AW + 1 > 10) ? RAW_AW + 1 : 10;

  logic [RCW-1:0]  raw_cnt_r, raw_cnt_nxt;
  logic [ECW-1:0]  enc_cnt_r, enc_cnt_nxt;
  logic [7:0]      grp_rem_r, grp_rem_nxt;
  logic [7:0]      grp_code_r, grp_code_nxt;
  logic            serr_r, serr_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic [31:0]     dl_r, dl_nxt;
  logic [7:0]      shadow_r [ccfd_pkg::HDR_BYTES];
  logic [7:0]      hdr_r    [ccfd_pkg::HDR_BYTES];
  logic            hdr_load;
  logic [2:0]      last_err_r, last_err_nxt;
  logic [31:0]     drop_r, drop_nxt;

  logic            o_valid_r;
  logic [1:0]      o_code_r;
  logic            o_rd_r;
  ccfd_pkg::result_t o_res;

  ccfd_pkg::result_t       oq_mem_r [ccfd_pkg::OQ_DEPTH];
  logic [ccfd_pkg::OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [ccfd_pkg::OQ_CW-1:0] oq_cnt_r;
  logic            oq_pop;

  logic            issue;
  logic [1:0]      res_code;
  logic            rd_hit;
  logic            put_en;
  logic [7:0]      put_val;
  logic            zero_ins;
  logic [RCW-1:0]  raw_after;
  logic [2:0]      chk_err;
  logic [15:0]     plen;
  logic            cmd_bad;
  logic [PW-1:0]   pos;
  logic [7:0]      ram_rdata;
  logic            ram_we;

  // Credit: the item plus the one in the result stage must fit in the queue.
  assign issue = q_valid &&
                 ((oq_cnt_r + ccfd_pkg::OQ_CW'(o_valid_r)) < ccfd_pkg::OQ_CW'(ccfd_pkg::OQ_DEPTH));
  assign q_pop = issue;
  assign pos   = PW'(ccfd_pkg::HDR_BYTES) + PW'(q_item.payload_index);

  // Frame checks from current state, in priority order.
  always_comb begin
    plen    = {shadow_r[ccfd_pkg::OFS_PLEN+1], shadow_r[ccfd_pkg::OFS_PLEN]};
    cmd_bad = (shadow_r[ccfd_pkg::OFS_CMD][7:6] != 2'd0) ||
              !cfg.known_command_mask[shadow_r[ccfd_pkg::OFS_CMD][5:0]];
    if (serr_r || grp_rem_r != 8'd0) begin
      chk_err = ccfd_pkg::ERR_INVALID;
    end else if (raw_cnt_r < RCW'(ccfd_pkg::MIN_FRAME)) begin
      chk_err = ccfd_pkg::ERR_LEN;
    end else if (~crc_r != dl_r) begin
      chk_err = ccfd_pkg::ERR_CRC;
    end else if ({shadow_r[1], shadow_r[0]} != cfg.frame_magic ||
                 shadow_r[ccfd_pkg::OFS_RSVD] != 8'd0) begin
      chk_err = ccfd_pkg::ERR_INVALID;
    end else if (shadow_r[ccfd_pkg::OFS_VERSION] != cfg.protocol_version) begin
      chk_err = ccfd_pkg::ERR_VERSION;
    end else if (cmd_bad) begin
      chk_err = ccfd_pkg::ERR_CMD;
    end else if (plen > {7'd0, cfg.max_payload} ||
                 BW'(raw_cnt_r) != BW'(ccfd_pkg::MIN_FRAME) + BW'(plen)) begin
      chk_err = ccfd_pkg::ERR_LEN;
    end else begin
      chk_err = ccfd_pkg::ERR_OK;
    end
  end

  always_comb begin
    raw_cnt_nxt  = raw_cnt_r;
    enc_cnt_nxt  = enc_cnt_r;
    grp_rem_nxt  = grp_rem_r;
    grp_code_nxt = grp_code_r;
    serr_nxt     = serr_r;
    crc_nxt      = crc_r;
    dl_nxt       = dl_r;
    last_err_nxt = last_err_r;
    drop_nxt     = drop_r;
    hdr_load     = 1'b0;
    res_code     = ccfd_pkg::RES_NONE;
    rd_hit       = 1'b0;
    put_en       = 1'b0;
    put_val      = 8'd0;
    zero_ins     = (enc_cnt_r != '0) && (grp_code_r != ccfd_pkg::COBS_LONG_CODE);
    raw_after    = raw_cnt_r + RCW'(zero_ins);
    if (issue) begin
      case (q_item.kind)
        ccfd_pkg::KIND_READ: begin
          rd_hit = (pos < PW'(RAW_DEPTH));
        end
        ccfd_pkg::KIND_DATA: begin
          if (enc_cnt_r >= ECW'(ENCODED_DEPTH)) begin
            // encoded overflow: drop and restart
            raw_cnt_nxt  = '0;
            enc_cnt_nxt  = '0;
            grp_rem_nxt  = 8'd0;
            grp_code_nxt = 8'd0;
            serr_nxt     = 1'b0;
            crc_nxt      = ccfd_pkg::CRC_INIT;
            dl_nxt       = 32'd0;
            drop_nxt     = drop_r + 32'd1;
            last_err_nxt = ccfd_pkg::ERR_LEN;
            res_code     = ccfd_pkg::RES_DROP;
          end else begin
            if (!serr_r) begin
              if (grp_rem_r == 8'd0) begin
                if (zero_ins && raw_cnt_r >= RCW'(RAW_DEPTH)) begin
                  serr_nxt = 1'b1;
                end else begin
                  put_en       = zero_ins;
                  grp_code_nxt = q_item.data_byte;
                  grp_rem_nxt  = q_item.data_byte - 8'd1;
                  if (GW'(grp_rem_nxt) > GW'(RAW_DEPTH) - GW'(raw_after)) begin
                    serr_nxt = 1'b1;
                  end
                end
              end else begin
                put_en      = 1'b1;
                put_val     = q_item.data_byte;
                grp_rem_nxt = grp_rem_r - 8'd1;
              end
            end
            enc_cnt_nxt = enc_cnt_r + 1'b1;
          end
        end
        ccfd_pkg::KIND_DELIM: begin
          if (enc_cnt_r != '0) begin
            if (chk_err == ccfd_pkg::ERR_OK) begin
              hdr_load = 1'b1;
              res_code = ccfd_pkg::RES_GOOD;
            end else begin
              drop_nxt = drop_r + 32'd1;
              res_code = ccfd_pkg::RES_DROP;
            end
            last_err_nxt = chk_err;
            raw_cnt_nxt  = '0;
            enc_cnt_nxt  = '0;
            grp_rem_nxt  = 8'd0;
            grp_code_nxt = 8'd0;
            serr_nxt     = 1'b0;
            crc_nxt      = ccfd_pkg::CRC_INIT;
            dl_nxt       = 32'd0;
          end
        end
        default: begin
        end
      endcase
    end
    if (put_en) begin
      if (raw_cnt_r >= RCW'(ccfd_pkg::CRC_BYTES)) begin
        crc_nxt = ccfd_pkg::crc32_byte(crc_r, dl_r[7:0]);
      end
      dl_nxt      = {put_val, dl_r[31:8]};
      raw_cnt_nxt = raw_cnt_r + 1'b1;
    end
  end

  assign ram_we = put_en && (raw_cnt_r < RCW'(RAW_DEPTH));

  ccfd_ram #(
    .WIDTH (8),
    .DEPTH (RAW_DEPTH)
  ) u_raw_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (raw_cnt_r[RAW_AW-1:0]),
    .wdata (put_val),
    .raddr (pos[RAW_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_cnt_r  <= '0;
      enc_cnt_r  <= '0;
      grp_rem_r  <= 8'd0;
      grp_code_r <= 8'd0;
      serr_r     <= 1'b0;
      crc_r      <= ccfd_pkg::CRC_INIT;
      dl_r       <= 32'd0;
      last_err_r <= ccfd_pkg::ERR_OK;
      drop_r     <= 32'd0;
      o_valid_r  <= 1'b0;
      for (int i = 0; i < ccfd_pkg::HDR_BYTES; i++) begin
        hdr_r[i] <= 8'd0;
      end
    end else begin
      raw_cnt_r  <= raw_cnt_nxt;
      enc_cnt_r  <= enc_cnt_nxt;
      grp_rem_r  <= grp_rem_nxt;
      grp_code_r <= grp_code_nxt;
      serr_r     <= serr_nxt;
      crc_r      <= crc_nxt;
      dl_r       <= dl_nxt;
      last_err_r <= last_err_nxt;
      drop_r     <= drop_nxt;
      o_valid_r  <= issue;
      if (hdr_load) begin
        for (int i = 0; i < ccfd_pkg::HDR_BYTES; i++) begin
          hdr_r[i] <= shadow_r[i];
        end
      end
    end
  end

  // header bytes mirrored in flops for the checks and the latch
  always_ff @(posedge clk) begin
    if (put_en && raw_cnt_r < RCW'(ccfd_pkg::HDR_BYTES)) begin
      shadow_r[raw_cnt_r[ccfd_pkg::HDR_IW-1:0]] <= put_val;
    end
    o_code_r <= res_code;
    o_rd_r   <= rd_hit;
  end

  // Result stage: state registers now hold the values after that item.
  always_comb begin
    o_res.decode_result   = o_code_r;
    o_res.error_code      = last_err_r;
    o_res.frame_version   = hdr_r[ccfd_pkg::OFS_VERSION];
    o_res.frame_command   = hdr_r[ccfd_pkg::OFS_CMD];
    o_res.frame_flags     = hdr_r[ccfd_pkg::OFS_FLAGS];
    o_res.sequence_number = {hdr_r[ccfd_pkg::OFS_SEQ+3], hdr_r[ccfd_pkg::OFS_SEQ+2],
                             hdr_r[ccfd_pkg::OFS_SEQ+1], hdr_r[ccfd_pkg::OFS_SEQ]};
    o_res.byte_offset     = {hdr_r[ccfd_pkg::OFS_OFFSET+3], hdr_r[ccfd_pkg::OFS_OFFSET+2],
                             hdr_r[ccfd_pkg::OFS_OFFSET+1], hdr_r[ccfd_pkg::OFS_OFFSET]};
    o_res.payload_length  = {hdr_r[ccfd_pkg::OFS_PLEN+1][0], hdr_r[ccfd_pkg::OFS_PLEN]};
    o_res.frame_status    = {hdr_r[ccfd_pkg::OFS_STATUS+1], hdr_r[ccfd_pkg::OFS_STATUS]};
    o_res.payload_byte    = o_rd_r ? ram_rdata : 8'd0;
    o_res.dropped_count   = drop_r;
  end

  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_mem_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (o_valid_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + ccfd_pkg::OQ_CW'(o_valid_r) - ccfd_pkg::OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (o_valid_r) begin
      oq_mem_r[oq_wp_r] <= o_res;
    end
  end

  `CCFD_ASSERT(a_raw_bound, clk, rst_n, 1'b1, raw_cnt_r <= RCW'(RAW_DEPTH), "raw count past depth")
  `CCFD_ASSERT(a_oq_room, clk, rst_n, o_valid_r, oq_cnt_r < ccfd_pkg::OQ_CW'(ccfd_pkg::OQ_DEPTH), "result queue overrun")
  `CCFD_ASSERT_NEXT(a_delim_restart, clk, rst_n, issue && q_item.kind == ccfd_pkg::KIND_DELIM, enc_cnt_r == '0 && crc_r == ccfd_pkg::CRC_INIT, "no restart after delimiter")
  `CCFD_ASSERT_NEXT(a_drop_count, clk, rst_n, issue && res_code == ccfd_pkg::RES_DROP, drop_r == $past(drop_r) + 32'd1, "drop not counted")
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccfd_pkg::*;

  localparam int RAW_SLOTS  = 512;
  localparam int ENC_SLOTS  = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  // Clock, reset and DUT pins. Every signal the bench drives starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic [8:0]  in_payload_index = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_decode_result;
  logic [2:0]  out_error_code;
  logic [7:0]  out_frame_version;
  logic [7:0]  out_frame_command;
  logic [7:0]  out_frame_flags;
  logic [31:0] out_sequence_number;
  logic [31:0] out_byte_offset;
  logic [8:0]  out_payload_length;
  logic [15:0] out_frame_status;
  logic [7:0]  out_payload_byte;
  logic [31:0] out_dropped_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  always #10 clk = ~clk;

  cobs_crc_frame_deframer uut (
    .clk, .rst_n,
    .in_push, .in_full, .in_command, .in_data_byte, .in_payload_index,
    .out_empty, .out_pop, .out_decode_result, .out_error_code,
    .out_frame_version, .out_frame_command, .out_frame_flags,
    .out_sequence_number, .out_byte_offset, .out_payload_length,
    .out_frame_status, .out_payload_byte, .out_dropped_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // One link transaction: a pushed byte or a payload read.
  typedef struct {
    bit         rd;
    logic [7:0] b;
    logic [8:0] idx;
  } link_txn_t;

  // Frame faults the stimulus can inject.
  typedef enum {
    FLT_NONE, FLT_CRC, FLT_MAGIC, FLT_RSVD, FLT_VER, FLT_CMD_HIGH, FLT_CMD_MASK,
    FLT_PLEN_BIG, FLT_PLEN_MISMATCH, FLT_SHORT, FLT_TRUNC
  } fault_t;

  // Directed scenario kinds.
  typedef enum {ST_EMPTY, ST_ENC_OVF, ST_FRAME, ST_READ, ST_GROUP_OVF} scen_t;

  typedef struct {
    scen_t      kind;
    fault_t     flt;
    int         plen;
    int         idx;
    bit         typed;
    logic [1:0] res;
    logic [2:0] err;
  } plan_row_t;

  link_txn_t link_q[$];     // transactions waiting to be offered
  result_t   result_q[$];   // predicted results, oldest first
  int        mismatches = 0;
  int        send_idle = 29;
  int        recv_idle = 80;
  logic      rx_hold = 1'b0;
  bit        hold_go = 1'b0;

  // ---------------------------------------------------------------------
  // Deframer predictor: shadow copy of config and decode state.
  // ---------------------------------------------------------------------
  logic [15:0] m_magic = 16'h0;
  logic [7:0]  m_ver = 8'h01;
  logic [63:0] m_mask = '0;
  logic [8:0]  m_maxp = 9'd256;

  logic [7:0]  raw_mem [RAW_SLOTS];
  bit          raw_seen [RAW_SLOTS];   // entry written since reset
  int          raw_len = 0;
  int          enc_len = 0;
  int          grp_left = 0;
  int          grp_code = 0;
  bit          stuff_err = 0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] crc_tail = '0;
  logic [7:0]  hdr [HDR_BYTES] = '{default: 8'h00};
  logic [2:0]  last_err = ERR_OK;
  logic [31:0] drop_tot = '0;

  function automatic logic [31:0] crc_upd(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function void frame_restart();
    raw_len = 0;
    enc_len = 0;
    grp_left = 0;
    grp_code = 0;
    stuff_err = 0;
    crc_acc = CRC_INIT;
    crc_tail = '0;
  endfunction

  // CRC trails the raw stream by four bytes so the tail holds the received CRC.
  function void put_raw(logic [7:0] b);
    if (raw_len < RAW_SLOTS) begin
      raw_mem[raw_len] = b;
      raw_seen[raw_len] = 1;
    end
    if (raw_len >= CRC_BYTES) crc_acc = crc_upd(crc_acc, crc_tail[7:0]);
    crc_tail = {b, crc_tail[31:8]};
    raw_len++;
  endfunction

  function void push_nz(logic [7:0] b);
    if (!stuff_err) begin
      if (grp_left == 0) begin
        // implied zero between groups, except after a long (0xFF) group
        if (enc_len > 0 && grp_code != COBS_LONG_CODE) begin
          if (raw_len >= RAW_SLOTS) stuff_err = 1;
          else put_raw(8'h00);
        end
        if (!stuff_err) begin
          grp_code = b;
          grp_left = int'(b) - 1;
          if (grp_left > RAW_SLOTS - raw_len) stuff_err = 1;
        end
      end else begin
        put_raw(b);
        grp_left--;
      end
    end
    enc_len++;
  endfunction

  function logic [2:0] frame_error();
    logic [15:0] plen;
    logic [7:0]  cmd;
    if (stuff_err || grp_left != 0) return ERR_INVALID;
    if (raw_len < MIN_FRAME) return ERR_LEN;
    if (~crc_acc != crc_tail) return ERR_CRC;
    if ({raw_mem[1], raw_mem[0]} != m_magic || raw_mem[OFS_RSVD] != 8'h00)
      return ERR_INVALID;
    if (raw_mem[OFS_VERSION] != m_ver) return ERR_VERSION;
    cmd = raw_mem[OFS_CMD];
    if (cmd >= 64 || !m_mask[cmd[5:0]]) return ERR_CMD;
    plen = {raw_mem[OFS_PLEN+1], raw_mem[OFS_PLEN]};
    if (plen > m_maxp || raw_len - CRC_BYTES != HDR_BYTES + int'(plen)) return ERR_LEN;
    return ERR_OK;
  endfunction

  function result_t decode_step(bit rd, logic [7:0] b, logic [8:0] idx);
    result_t    r;
    int         pos;
    logic [2:0] e;
    r = '0;
    pos = HDR_BYTES + int'(idx);
    if (rd) begin
      if (pos < RAW_SLOTS) r.payload_byte = raw_mem[pos];
    end else if (b != 8'h00) begin
      if (enc_len >= ENC_SLOTS) begin
        frame_restart();
        drop_tot++;
        last_err = ERR_LEN;
        r.decode_result = RES_DROP;
      end else begin
        push_nz(b);
      end
    end else if (enc_len > 0) begin
      e = frame_error();
      if (e == ERR_OK) begin
        for (int i = 0; i < HDR_BYTES; i++) hdr[i] = raw_mem[i];
        r.decode_result = RES_GOOD;
      end else begin
        drop_tot++;
        r.decode_result = RES_DROP;
      end
      last_err = e;
      frame_restart();
    end
    r.error_code      = last_err;
    r.frame_version   = hdr[OFS_VERSION];
    r.frame_command   = hdr[OFS_CMD];
    r.frame_flags     = hdr[OFS_FLAGS];
    r.sequence_number = {hdr[9], hdr[8], hdr[7], hdr[6]};
    r.byte_offset     = {hdr[13], hdr[12], hdr[11], hdr[10]};
    r.payload_length  = {hdr[15][0], hdr[14]};
    r.frame_status    = {hdr[17], hdr[16]};
    r.dropped_count   = drop_tot;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers. Prediction happens when a transaction is queued;
  // order is preserved, so the shadow state matches acceptance order.
  // ---------------------------------------------------------------------
  function void emit(bit rd, logic [7:0] b, logic [8:0] idx, bit typed = 0,
                     logic [1:0] tres = RES_NONE, logic [2:0] terr = ERR_OK);
    result_t   r;
    link_txn_t t;
    r = decode_step(rd, b, idx);
    // directed rows carry hand-written outcome for the last transaction
    if (typed) begin
      r.decode_result = tres;
      r.error_code = terr;
    end
    result_q.push_back(r);
    t.rd = rd;
    t.b = b;
    t.idx = idx;
    link_q.push_back(t);
  endfunction

  function void push_byte(logic [7:0] b);
    emit(0, b, 9'($urandom));
  endfunction

  // Reads only land on buffer entries that were written since reset.
  function void try_read(int idx);
    if (idx >= 0 && idx < 490 && raw_seen[HDR_BYTES + idx]) emit(1, $urandom, 9'(idx));
  endfunction

  logic [7:0] raw_frame[$];
  logic [7:0] enc_frame[$];

  function void cobs_pack();
    int code_at, n;
    enc_frame.delete();
    code_at = 0;
    enc_frame.push_back(8'h00);
    n = 1;
    foreach (raw_frame[i]) begin
      if (raw_frame[i] == 8'h00) begin
        enc_frame[code_at] = 8'(n);
        code_at = enc_frame.size();
        enc_frame.push_back(8'h00);
        n = 1;
      end else begin
        enc_frame.push_back(raw_frame[i]);
        n++;
        if (n == 255) begin
          enc_frame[code_at] = COBS_LONG_CODE;
          code_at = enc_frame.size();
          enc_frame.push_back(8'h00);
          n = 1;
        end
      end
    end
    enc_frame[code_at] = 8'(n);
  endfunction

  function logic [7:0] pay_byte();
    return ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  // Build, encode and push one frame plus its delimiter.
  function void send_frame(int plen, fault_t f, bit typed = 0,
                           logic [1:0] tres = RES_NONE, logic [2:0] terr = ERR_OK);
    logic [7:0]  cmd;
    logic [15:0] pf, mg;
    logic [31:0] c;
    bit          want;
    raw_frame.delete();
    if (f == FLT_SHORT) begin
      repeat ($urandom_range(1, MIN_FRAME - 1)) raw_frame.push_back(pay_byte());
    end else begin
      want = (f != FLT_CMD_MASK);
      cmd = 8'($urandom_range(0, 63));
      for (int k = 0; k < 16 && m_mask[cmd[5:0]] != want; k++)
        cmd = 8'($urandom_range(0, 63));
      if (f == FLT_CMD_HIGH) cmd = 8'($urandom_range(64, 255));
      pf = 16'(plen);
      if (f == FLT_PLEN_BIG) pf = 16'($urandom_range(int'(m_maxp) + 1, 65535));
      mg = m_magic;
      if (f == FLT_MAGIC) mg = mg ^ 16'($urandom_range(1, 65535));
      raw_frame.push_back(mg[7:0]);
      raw_frame.push_back(mg[15:8]);
      raw_frame.push_back(f == FLT_VER ? m_ver ^ 8'($urandom_range(1, 255)) : m_ver);
      raw_frame.push_back(cmd);
      raw_frame.push_back(pay_byte());                                // flags
      raw_frame.push_back(f == FLT_RSVD ? 8'($urandom_range(1, 255)) : 8'h00);
      repeat (8) raw_frame.push_back(pay_byte());                     // seq, offset
      raw_frame.push_back(pf[7:0]);
      raw_frame.push_back(pf[15:8]);
      repeat (2) raw_frame.push_back(pay_byte());                     // status
      repeat (plen + (f == FLT_PLEN_MISMATCH)) raw_frame.push_back(pay_byte());
      c = CRC_INIT;
      foreach (raw_frame[i]) c = crc_upd(c, raw_frame[i]);
      c = ~c;
      if (f == FLT_CRC) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) raw_frame.push_back(c[8*i +: 8]);
    end
    cobs_pack();
    // unfinished group: a code byte promising more than follows
    if (f == FLT_TRUNC) begin
      enc_frame.push_back(8'h05);
      enc_frame.push_back(8'($urandom_range(1, 255)));
    end
    foreach (enc_frame[i]) push_byte(enc_frame[i]);
    emit(0, 8'h00, 9'($urandom), typed, tres, terr);
  endfunction

  // ---------------------------------------------------------------------
  // Input side: offer link_q[0], move on once the transaction is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) void'(link_q.pop_front());
      // a stalled offer must stay put
      if (!(in_push && in_full)) begin
        if (link_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_push          <= 1'b1;
          in_command       <= link_q[0].rd;
          in_data_byte     <= link_q[0].b;
          in_payload_index <= link_q[0].idx;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result side: pop at random, compare every field with the oldest
  // prediction.
  // ---------------------------------------------------------------------
  task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          e = result_q.pop_front();
          cmp("decode_result",   e.decode_result,   out_decode_result);
          cmp("error_code",      e.error_code,      out_error_code);
          cmp("frame_version",   e.frame_version,   out_frame_version);
          cmp("frame_command",   e.frame_command,   out_frame_command);
          cmp("frame_flags",     e.frame_flags,     out_frame_flags);
          cmp("sequence_number", e.sequence_number, out_sequence_number);
          cmp("byte_offset",     e.byte_offset,     out_byte_offset);
          cmp("payload_length",  e.payload_length,  out_payload_length);
          cmp("frame_status",    e.frame_status,    out_frame_status);
          cmp("payload_byte",    e.payload_byte,    out_payload_byte);
          cmp("dropped_count",   e.dropped_count,   out_dropped_count);
        end
      end
      out_pop <= !rx_hold && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Long receiver hold-off so both queues fill and in_full asserts.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: cycles with work pending but no transaction on either side.
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (link_q.size() == 0 && result_q.size() == 0)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Config port and phase control
  // ---------------------------------------------------------------------
  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block must be drained before registers change.
  task automatic drain();
    while (link_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_cfg(logic [15:0] mg, logic [7:0] ver, logic [63:0] mask,
                         logic [8:0] maxp);
    drain();
    reg_write(REG_MAGIC, {48'd0, mg});
    reg_write(REG_VERSION, {56'd0, ver});
    reg_write(REG_CMDMASK, mask);
    reg_write(REG_MAXPAY, {55'd0, maxp});
    m_magic = mg;
    m_ver = ver;
    m_mask = mask;
    m_maxp = maxp;
  endtask

  // Random traffic: mostly well-formed frames, some faulty, reads and noise.
  task automatic random_phase(int n_txn);
    int     target, r, cap, plen;
    fault_t f;
    target = link_q.size() + n_txn;
    while (link_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        cap = (m_maxp > 24) ? 24 : int'(m_maxp);
        if ($urandom_range(0, 99) < 4) cap = (m_maxp > 480) ? 480 : int'(m_maxp);
        plen = $urandom_range(0, cap);
        f = ($urandom_range(0, 1) == 0) ? FLT_NONE
                                        : fault_t'($urandom_range(1, FLT_TRUNC));
        if (f == FLT_PLEN_MISMATCH && plen > 400) f = FLT_NONE;
        send_frame(plen, f);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) try_read($urandom_range(0, 489));
      end else if (r < 95) begin
        repeat ($urandom_range(1, 5)) push_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
      end else begin
        push_byte(8'h00);
      end
    end
  endtask

  // Directed plan. Outcome typed in where it follows directly from the
  // frame built; everything else is left to the predictor.
  plan_row_t plan [20] = '{
    '{ST_EMPTY,     FLT_NONE,          0,   0,   1, RES_NONE, ERR_OK},      // fresh reset
    '{ST_ENC_OVF,   FLT_NONE,          0,   0,   1, RES_DROP, ERR_LEN},     // encoded overflow
    '{ST_EMPTY,     FLT_NONE,          0,   0,   1, RES_NONE, ERR_LEN},     // restarted decoder
    '{ST_FRAME,     FLT_NONE,          0,   0,   1, RES_GOOD, ERR_OK},      // empty payload
    '{ST_FRAME,     FLT_NONE,          490, 0,   1, RES_GOOD, ERR_OK},      // full buffer
    '{ST_READ,      FLT_NONE,          0,   0,   0, RES_NONE, ERR_OK},
    '{ST_READ,      FLT_NONE,          0,   489, 0, RES_NONE, ERR_OK},
    '{ST_READ,      FLT_NONE,          0,   256, 0, RES_NONE, ERR_OK},
    '{ST_FRAME,     FLT_CRC,           5,   0,   1, RES_DROP, ERR_CRC},
    '{ST_FRAME,     FLT_MAGIC,         3,   0,   1, RES_DROP, ERR_INVALID},
    '{ST_FRAME,     FLT_RSVD,          3,   0,   1, RES_DROP, ERR_INVALID},
    '{ST_FRAME,     FLT_VER,           3,   0,   1, RES_DROP, ERR_VERSION},
    '{ST_FRAME,     FLT_CMD_HIGH,      3,   0,   1, RES_DROP, ERR_CMD},
    '{ST_FRAME,     FLT_PLEN_BIG,      3,   0,   1, RES_DROP, ERR_LEN},
    '{ST_FRAME,     FLT_PLEN_MISMATCH, 3,   0,   1, RES_DROP, ERR_LEN},
    '{ST_FRAME,     FLT_SHORT,         0,   0,   1, RES_DROP, ERR_LEN},
    '{ST_FRAME,     FLT_TRUNC,         3,   0,   1, RES_DROP, ERR_INVALID},
    '{ST_GROUP_OVF, FLT_NONE,          0,   0,   1, RES_DROP, ERR_INVALID}, // group too long
    '{ST_FRAME,     FLT_NONE,          7,   0,   1, RES_GOOD, ERR_OK},
    '{ST_EMPTY,     FLT_NONE,          0,   0,   1, RES_NONE, ERR_OK}
  };

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sender idles 29%, receiver 80%.
    send_idle = 29;
    recv_idle = 80;
    set_cfg(16'hA55A, 8'h01, {64{1'b1}}, 9'd490);
    foreach (plan[i]) begin
      case (plan[i].kind)
        ST_EMPTY: begin
          emit(0, 8'h00, 9'h1FF, plan[i].typed, plan[i].res, plan[i].err);
        end
        ST_ENC_OVF: begin
          // all-0x01 stream: implied zeros fill the raw buffer, then the
          // encoded count runs out and the next byte drops the frame
          repeat (ENC_SLOTS) push_byte(8'h01);
          emit(0, 8'h01, 9'h000, plan[i].typed, plan[i].res, plan[i].err);
        end
        ST_FRAME: begin
          send_frame(plan[i].plen, plan[i].flt, plan[i].typed, plan[i].res, plan[i].err);
        end
        ST_READ: begin
          try_read(plan[i].idx);
        end
        ST_GROUP_OVF: begin
          repeat (2) begin
            push_byte(COBS_LONG_CODE);
            repeat (254) push_byte(8'($urandom_range(1, 255)));
          end
          push_byte(COBS_LONG_CODE);
          emit(0, 8'h00, 9'h0AA, plan[i].typed, plan[i].res, plan[i].err);
        end
        default: ;
      endcase
    end

    // Random part, first with the receiver mostly stalled.
    set_cfg(16'h0000, 8'h00, {$urandom, $urandom}, 9'd490);
    random_phase(500);
    set_cfg(16'hFFFF, 8'hFF, 64'h0, 9'd0);       // no command known
    random_phase(250);

    // Then with the sender mostly idle.
    send_idle = 80;
    recv_idle = 29;
    set_cfg(16'($urandom), 8'($urandom), {$urandom, $urandom} | 64'h1,
            9'($urandom_range(0, 490)));
    random_phase(400);

    // No idling, plus one long receiver hold-off.
    send_idle = 0;
    recv_idle = 0;
    set_cfg(16'h1234, 8'h01, {64{1'b1}}, 9'd256);
    hold_go = 1'b1;
    random_phase(400);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
